>>> src/nal_unit_chunk_splitter_macros.svh
// Assertion macros used by the chunk splitter result queue.
`ifndef NAL_UNIT_CHUNK_SPLITTER_MACROS_SVH
`define NAL_UNIT_CHUNK_SPLITTER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define NCS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ncs: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define NCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ncs: next-cycle check failed");

`endif

>>> src/ncs_pkg.sv
// Types, constants and helper functions of the NAL unit chunk splitter.
package ncs_pkg;

    localparam int WIN_DEPTH = 6;
    localparam int BUF_DEPTH = 7;
    localparam int PADDR_W   = 3;

    // register index as decoded from paddr[2]
    localparam logic REG_CODEC = 1'b0;

    // start code lengths
    localparam logic [2:0] SC_NONE = 3'd0;
    localparam logic [2:0] SC_LEN3 = 3'd3;
    localparam logic [2:0] SC_LEN4 = 3'd4;

    // window fill at which the oldest byte is tested before the first start code
    localparam logic [2:0] OPEN_FILL = 3'd5;

    // auxiliary unit type ranges
    localparam logic [4:0] AVC_AUX_LO  = 5'd6;
    localparam logic [4:0] AVC_AUX_HI  = 5'd9;
    localparam logic [5:0] HEVC_AUX_LO = 6'd32;
    localparam logic [5:0] HEVC_AUX_HI = 6'd35;

    typedef logic [WIN_DEPTH-1:0][7:0] ncs_win_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       first_of_chunk;
        logic       last_of_chunk;
        logic       stream_end;
        logic       last_result;
    } ncs_res_t;

    typedef struct packed {
        logic [2:0]                   count;
        ncs_res_t [WIN_DEPTH-1:0]     res;
    } ncs_batch_t;

    // Start code length at byte i among the first n window bytes.
    function automatic logic [2:0] code_len(ncs_win_t w, int i, logic [2:0] n);
        logic [WIN_DEPTH+2:0][7:0] p;
        logic [2:0]                len;
        begin
            p   = {24'h0, w};
            len = SC_NONE;
            if ((i + 3 < int'(n)) && p[i] == 8'h00 && p[i+1] == 8'h00 &&
                p[i+2] == 8'h00 && p[i+3] == 8'h01)
                len = SC_LEN4;
            else if ((i + 2 < int'(n)) && p[i] == 8'h00 && p[i+1] == 8'h00 &&
                     p[i+2] == 8'h01)
                len = SC_LEN3;
            return len;
        end
    endfunction

    // Unit header classification: 1 = VCL, 0 = auxiliary.
    function automatic logic is_vcl(logic [7:0] h, logic hevc);
        logic [5:0] t6;
        logic [4:0] t5;
        begin
            t6 = h[6:1];
            t5 = h[4:0];
            if (hevc)
                return !(t6 >= HEVC_AUX_LO && t6 <= HEVC_AUX_HI);
            return !(t5 >= AVC_AUX_LO && t5 <= AVC_AUX_HI);
        end
    endfunction

endpackage

>>> src/ncs_if.sv
// Valid/ready stream interfaces for the input bytes and the chunk results.
interface ncs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_stream;

    modport source (output valid, output data_byte, output end_of_stream, input ready);
    modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface ncs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       first_of_chunk;
    logic       last_of_chunk;
    logic       stream_end;
    logic       last_result;

    modport source (output valid, output out_byte, output first_of_chunk,
                    output last_of_chunk, output stream_end, output last_result,
                    input ready);
    modport sink   (input valid, input out_byte, input first_of_chunk,
                    input last_of_chunk, input stream_end, input last_result,
                    output ready);
endinterface

>>> src/ncs_cfg.sv
// APB configuration register: codec selection.
module ncs_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ncs_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output logic                        codec_is_hevc
);
    import ncs_pkg::*;

    logic codec_reg;
    logic codec_next;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_CODEC);

    assign codec_next = wr_en ? pwdata[0] : codec_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            codec_reg <= 1'b0;
        else
            codec_reg <= codec_next;
    end

    // bits [1:0] of paddr are the byte lane and ignored
    assign prdata        = (paddr[2] == REG_CODEC) ? {31'h0, codec_reg} : 32'h0;
    assign codec_is_hevc = codec_reg;

endmodule

>>> src/ncs_scan.sv
// Window, start code detection and chunk grouping; one step per byte.
module ncs_scan (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          data_byte,
    input  logic                end_of_stream,
    input  logic                codec_is_hevc,
    output ncs_pkg::ncs_batch_t batch
);
    import ncs_pkg::*;

    ncs_win_t   win_reg, win_next, win_new, shifted;
    logic [2:0] fill_reg, fill_next;
    logic       open_reg, open_next;
    logic       fvcl_reg, fvcl_next;
    logic [1:0] skip_reg, skip_next;
    logic       pfm_reg, pfm_next;

    logic [2:0] wr_idx, nf, off, start, count;
    logic       first, cut, vcl;

    always_comb
    begin
        wr_idx  = (fill_reg >= 3'(WIN_DEPTH)) ? 3'(WIN_DEPTH - 1) : fill_reg;
        win_new = win_reg;
        win_new[wr_idx] = data_byte;
        nf      = wr_idx + 3'd1;

        win_next  = win_reg;
        fill_next = fill_reg;
        open_next = open_reg;
        fvcl_next = fvcl_reg;
        skip_next = skip_reg;
        pfm_next  = pfm_reg;

        batch   = '0;
        start   = 3'd0;
        count   = 3'd0;
        first   = 1'b0;
        off     = SC_NONE;
        cut     = 1'b0;
        vcl     = 1'b0;
        shifted = win_new;

        if (step)
        begin
            if (end_of_stream)
            begin
                // flush: whole window (open chunk) or from the first start code
                if (open_reg)
                begin
                    start = 3'd0;
                    first = pfm_reg;
                end
                else
                begin
                    start = nf;
                    for (int i = WIN_DEPTH - 1; i >= 0; i--)
                    begin
                        if (code_len(win_new, i, nf) != SC_NONE)
                            start = 3'(i);
                    end
                    first = 1'b1;
                end
                count   = nf - start;
                shifted = ncs_win_t'(win_new >> {start, 3'b000});
                batch.count = count;
                for (int k = 0; k < WIN_DEPTH; k++)
                begin
                    if (3'(k) < count)
                    begin
                        batch.res[k].out_byte       = shifted[k];
                        batch.res[k].first_of_chunk = (k == 0) ? first : 1'b0;
                        batch.res[k].last_of_chunk  = (3'(k) == count - 3'd1);
                        batch.res[k].stream_end     = (3'(k) == count - 3'd1);
                        batch.res[k].last_result    = (3'(k) == count - 3'd1);
                    end
                end
                win_next  = '0;
                fill_next = 3'd0;
                open_next = 1'b0;
                fvcl_next = 1'b0;
                skip_next = 2'd0;
                pfm_next  = 1'b1;
            end
            else if (!open_reg)
            begin
                win_next  = win_new;
                fill_next = nf;
                if (nf >= OPEN_FILL)
                begin
                    off = code_len(win_new, 0, nf);
                    if (off != SC_NONE)
                    begin
                        open_next = 1'b1;
                        fvcl_next = is_vcl(win_new[off], codec_is_hevc);
                        skip_next = 2'(off - 3'd1);
                        pfm_next  = 1'b1;
                    end
                    else
                    begin
                        win_next  = ncs_win_t'(win_new >> 8);
                        fill_next = nf - 3'd1;
                    end
                end
            end
            else if (nf < 3'(WIN_DEPTH))
            begin
                win_next  = win_new;
                fill_next = nf;
            end
            else
            begin
                if (skip_reg != 2'd0)
                begin
                    skip_next = skip_reg - 2'd1;
                end
                else
                begin
                    off = code_len(win_new, 1, 3'(WIN_DEPTH));
                    if (off != SC_NONE)
                    begin
                        vcl = is_vcl(win_new[3'd1 + off], codec_is_hevc);
                        if (fvcl_reg || vcl)
                        begin
                            cut       = 1'b1;
                            fvcl_next = vcl;
                            skip_next = 2'(off - 3'd1);
                        end
                    end
                end
                batch.count                 = 3'd1;
                batch.res[0].out_byte       = win_new[0];
                batch.res[0].first_of_chunk = pfm_reg;
                batch.res[0].last_of_chunk  = cut;
                batch.res[0].stream_end     = 1'b0;
                batch.res[0].last_result    = 1'b1;
                pfm_next  = cut;
                win_next  = ncs_win_t'(win_new >> 8);
                fill_next = nf - 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg  <= '0;
            fill_reg <= 3'd0;
            open_reg <= 1'b0;
            fvcl_reg <= 1'b0;
            skip_reg <= 2'd0;
            pfm_reg  <= 1'b1;
        end
        else
        begin
            win_reg  <= win_next;
            fill_reg <= fill_next;
            open_reg <= open_next;
            fvcl_reg <= fvcl_next;
            skip_reg <= skip_next;
            pfm_reg  <= pfm_next;
        end
    end

endmodule

>>> src/ncs_obuf.sv
// Result queue: takes a batch of up to six results, sends one per cycle while chunk.ready is high.
`include "nal_unit_chunk_splitter_macros.svh"

module ncs_obuf (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  ncs_pkg::ncs_batch_t batch,
    output logic                space,
    ncs_out_if.source           chunk
);
    import ncs_pkg::*;

    ncs_res_t [BUF_DEPTH-1:0] buf_reg, buf_next;
    logic [2:0]               cnt_reg, cnt_next;
    logic [2:0]               base;
    logic [2:0]               slot;
    logic                     pop;
    logic                     tail_lr;

    assign chunk.valid          = (cnt_reg != 3'd0);
    assign chunk.out_byte       = buf_reg[0].out_byte;
    assign chunk.first_of_chunk = buf_reg[0].first_of_chunk;
    assign chunk.last_of_chunk  = buf_reg[0].last_of_chunk;
    assign chunk.stream_end     = buf_reg[0].stream_end;
    assign chunk.last_result    = buf_reg[0].last_result;

    assign pop   = chunk.valid && chunk.ready;
    assign base  = cnt_reg - {2'b00, pop};
    // a new batch goes in only behind at most one waiting result
    assign space = (cnt_reg <= 3'd1);

    // last result of the incoming batch
    assign tail_lr = batch.res[batch.count - 3'd1].last_result;

    always_comb
    begin
        slot = 3'd0;
        for (int j = 0; j < BUF_DEPTH - 1; j++)
            buf_next[j] = pop ? buf_reg[j+1] : buf_reg[j];
        buf_next[BUF_DEPTH-1] = buf_reg[BUF_DEPTH-1];
        cnt_next = base;
        if (push)
        begin
            for (int j = 0; j < BUF_DEPTH; j++)
            begin
                slot = 3'(j) - base;
                if (3'(j) >= base && slot < batch.count)
                    buf_next[j] = batch.res[slot];
            end
            cnt_next = base + batch.count;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 3'd0;
        else
            cnt_reg <= cnt_next;
    end

    `NCS_ASSERT_NOW(a_push_room, clk, rst_n, push, base <= 3'd1)
    `NCS_ASSERT_NOW(a_batch_tail, clk, rst_n, push && batch.count != 3'd0, tail_lr)
    `NCS_ASSERT_NEXT(a_drain, clk, rst_n, pop && !push, cnt_reg == $past(cnt_reg) - 3'd1)
    `NCS_ASSERT_NEXT(a_shown, clk, rst_n, push && batch.count != 3'd0, chunk.valid)

endmodule

>>> src/nal_unit_chunk_splitter.sv
// Throughput: one byte per cycle while no flush runs and results are taken;
// stream.ready is high whenever at most one result waits in the result queue.
// Path: input register, then result queue; a byte leaves five accepted bytes
// after it entered. An end-of-stream byte flushes up to six results, one per
// cycle from the queue while chunk.ready is high. Reset (rst_n low, asynchronous):
// window empty, no chunk open, queue empty, codec register back to H.264.
module nal_unit_chunk_splitter (
    input  logic                        clk,
    input  logic                        rst_n,
    ncs_in_if.sink                      stream,
    ncs_out_if.source                   chunk,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ncs_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import ncs_pkg::*;

    // input register stage
    logic       s1_valid_reg, s1_valid_next;
    logic [7:0] s1_byte_reg;
    logic       s1_eos_reg;
    logic       take;
    logic       advance;
    logic       space;

    logic       codec_is_hevc;
    ncs_batch_t batch;

    ncs_cfg u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .codec_is_hevc (codec_is_hevc)
    );

    // the held byte moves on once the queue has room for its batch
    assign advance      = s1_valid_reg && space;
    assign stream.ready = !s1_valid_reg || space;
    assign take         = stream.valid && stream.ready;
    assign s1_valid_next = take || (s1_valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    // payload: no reset needed
    always_ff @(posedge clk)
    begin
        if (take) begin
            s1_byte_reg <= stream.data_byte;
            s1_eos_reg  <= stream.end_of_stream;
        end
    end

    // window scan and grouping decision, one step per transfer
    ncs_scan u_scan (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (advance),
        .data_byte     (s1_byte_reg),
        .end_of_stream (s1_eos_reg),
        .codec_is_hevc (codec_is_hevc),
        .batch         (batch)
    );

    // result queue; each result leaves in a transfer of its own
    ncs_obuf u_obuf (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (advance),
        .batch (batch),
        .space (space),
        .chunk (chunk)
    );

endmodule

>>> test/tb_nal_unit_chunk_splitter.sv
// Self-checking testbench for the Annex B chunk splitter: directed table, then random streams.
module tb_nal_unit_chunk_splitter;
    import ncs_pkg::*;

    // cycles with no transfer on either stream before the run is declared hung
    localparam int STALL_LIMIT   = 2000;
    // quiet cycles after the last expected transfer; covers a flush that emits nothing
    localparam int SETTLE_CYCLES = 12;
    // long receiver hold-off, long enough to back the block up into its input
    localparam int HOLD_CYCLES   = 150;
    localparam int PHASE_ITEMS   = 160;
    localparam int SHOW_LIMIT    = 10;

    localparam logic [PADDR_W-1:0] CODEC_ADDR = {REG_CODEC, 2'b00};

    // how a directed row is checked: by the predictor, or by a result typed into the table
    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_NO_RESULT,
        ROW_ONE_RESULT
    } row_kind_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       eos;
        row_kind_t  kind;
        ncs_res_t   res;
    } dir_row_t;

    localparam ncs_res_t NONE_RES = '0;

    // Directed stream, H.264 headers (codec register at its reset value).
    localparam dir_row_t DIR_ROWS [25] = '{
        // noise ahead of the first start code is dropped
        '{8'hFF, 1'b0, ROW_NO_RESULT, NONE_RES},
        '{8'h00, 1'b0, ROW_NO_RESULT, NONE_RES},
        '{8'h00, 1'b0, ROW_NO_RESULT, NONE_RES},
        '{8'h00, 1'b0, ROW_NO_RESULT, NONE_RES},
        '{8'h01, 1'b0, ROW_NO_RESULT, NONE_RES},
        // SPS header: chunk opens on the 4-byte code, first unit auxiliary
        '{8'h67, 1'b0, ROW_NO_RESULT, NONE_RES},
        // window full: opening zero leaves with the first-of-chunk mark
        '{8'h42, 1'b0, ROW_ONE_RESULT, '{8'h00, 1'b1, 1'b0, 1'b0, 1'b1}},
        '{8'h00, 1'b0, ROW_PREDICT, NONE_RES},
        '{8'h00, 1'b0, ROW_PREDICT, NONE_RES},
        '{8'h01, 1'b0, ROW_PREDICT, NONE_RES},
        // PPS after SPS on a 3-byte code: auxiliary joins auxiliary, no cut
        '{8'h68, 1'b0, ROW_PREDICT, NONE_RES},
        '{8'h00, 1'b0, ROW_PREDICT, NONE_RES},
        '{8'h00, 1'b0, ROW_PREDICT, NONE_RES},
        '{8'h00, 1'b0, ROW_PREDICT, NONE_RES},
        '{8'h01, 1'b0, ROW_PREDICT, NONE_RES},
        // IDR slice: VCL unit cuts, the byte before its 4-byte code closes the chunk
        '{8'h65, 1'b0, ROW_ONE_RESULT, '{8'h68, 1'b0, 1'b1, 1'b0, 1'b1}},
        '{8'h88, 1'b0, ROW_ONE_RESULT, '{8'h00, 1'b1, 1'b0, 1'b0, 1'b1}},
        '{8'h80, 1'b0, ROW_PREDICT, NONE_RES},
        '{8'h00, 1'b0, ROW_PREDICT, NONE_RES},
        '{8'h00, 1'b0, ROW_PREDICT, NONE_RES},
        '{8'h01, 1'b0, ROW_PREDICT, NONE_RES},
        // SEI after a VCL chunk: cut before its 3-byte code
        '{8'h06, 1'b0, ROW_PREDICT, NONE_RES},
        '{8'hFF, 1'b0, ROW_ONE_RESULT, '{8'h80, 1'b0, 1'b1, 1'b0, 1'b1}},
        // end of stream with a full window: six transfers in one flush
        '{8'h00, 1'b1, ROW_PREDICT, NONE_RES},
        // end of stream on a lone byte with no start code: nothing comes out
        '{8'hFF, 1'b1, ROW_NO_RESULT, NONE_RES}
    };

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    ncs_in_if  byte_bus ();
    ncs_out_if chunk_bus ();

    nal_unit_chunk_splitter dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .stream  (byte_bus),
        .chunk   (chunk_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predictor state: delay window, chunk tracking and our copy of the codec register.
    logic [7:0] win [WIN_DEPTH];
    int         win_fill;
    logic       in_chunk;
    logic       lead_vcl;       // first unit of the open chunk is VCL
    int         skip_left;      // start code bytes not to be scanned again
    logic       mark_first;     // next emitted byte opens a chunk
    logic       codec_hevc = 1'b0;

    ncs_res_t   expected_chunk_bytes [$];
    logic [8:0] stream_q [$];   // {end_of_stream, data_byte}

    int src_idle_pct = 33;
    int snk_idle_pct = 45;
    int hold_left    = 0;
    int idle_cycles  = 0;
    int mismatches   = 0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic flag_mismatch(input string msg);
        mismatches++;
        if (mismatches <= SHOW_LIMIT)
            $display("%s", msg);
    endtask

    function automatic void clear_chunk_state();
        foreach (win[i])
            win[i] = 8'h00;
        win_fill   = 0;
        in_chunk   = 1'b0;
        lead_vcl   = 1'b0;
        skip_left  = 0;
        mark_first = 1'b1;
    endfunction

    function automatic void shift_out_oldest();
        if (win_fill == 0)
            return;
        for (int i = 0; i < WIN_DEPTH - 1; i++)
            win[i] = win[i + 1];
        win[WIN_DEPTH - 1] = 8'h00;
        win_fill--;
    endfunction

    // Start code length at window index i, looking only at the first n bytes.
    function automatic logic [2:0] code_len_at(int i, int n);
        if (n > WIN_DEPTH)
            n = WIN_DEPTH;
        if (i + 3 < n && win[i] == 8'h00 && win[i + 1] == 8'h00 &&
            win[i + 2] == 8'h00 && win[i + 3] == 8'h01)
            return SC_LEN4;
        if (i + 2 < n && win[i] == 8'h00 && win[i + 1] == 8'h00 && win[i + 2] == 8'h01)
            return SC_LEN3;
        return SC_NONE;
    endfunction

    // Unit header class under the current codec; 1 = VCL. Offset compare, wraps below LO.
    function automatic logic unit_is_vcl(logic [7:0] hdr);
        logic [5:0] d6;
        logic [4:0] d5;
        d6 = hdr[6:1] - HEVC_AUX_LO;
        d5 = hdr[4:0] - AVC_AUX_LO;
        if (codec_hevc)
            return d6 > (HEVC_AUX_HI - HEVC_AUX_LO);
        return d5 > (AVC_AUX_HI - AVC_AUX_LO);
    endfunction

    // Advance the chunk predictor by one accepted byte; queue its transfers when keep is set.
    function automatic void predict_chunk_bytes(logic [7:0] b, logic eos, bit keep);
        int         start;
        logic [2:0] len;
        logic       mark;
        logic       vcl;
        logic       cut;
        ncs_res_t   r;

        if (win_fill >= WIN_DEPTH)
            win_fill = WIN_DEPTH - 1;
        win[win_fill] = b;
        win_fill++;

        if (eos)
        begin
            // flush: open chunk continues from index 0, else from the first start code
            if (in_chunk)
            begin
                start = 0;
                mark  = mark_first;
            end
            else
            begin
                start = win_fill;
                for (int i = 0; i < win_fill; i++)
                begin
                    if (code_len_at(i, win_fill) != SC_NONE)
                    begin
                        start = i;
                        break;
                    end
                end
                mark = 1'b1;
            end
            for (int i = start; i < win_fill; i++)
            begin
                r.out_byte       = win[i];
                r.first_of_chunk = (i == start) ? mark : 1'b0;
                r.last_of_chunk  = (i == win_fill - 1);
                r.stream_end     = r.last_of_chunk;
                r.last_result    = r.last_of_chunk;
                if (keep)
                    expected_chunk_bytes.push_back(r);
            end
            clear_chunk_state();
            return;
        end

        if (!in_chunk)
        begin
            // hunting for the first start code at the head of the window
            if (win_fill >= OPEN_FILL)
            begin
                len = code_len_at(0, win_fill);
                if (len != SC_NONE)
                begin
                    in_chunk   = 1'b1;
                    lead_vcl   = unit_is_vcl(win[len]);
                    skip_left  = len - 1;
                    mark_first = 1'b1;
                end
                else
                    shift_out_oldest();
            end
            return;
        end

        if (win_fill < WIN_DEPTH)
            return;

        cut = 1'b0;
        if (skip_left != 0)
            skip_left--;
        else
        begin
            len = code_len_at(1, WIN_DEPTH);
            if (len != SC_NONE)
            begin
                vcl = unit_is_vcl(win[1 + len]);
                if (lead_vcl || vcl)
                begin
                    cut       = 1'b1;
                    lead_vcl  = vcl;
                    skip_left = len - 1;
                end
            end
        end
        r = '{win[0], mark_first, cut, 1'b0, 1'b1};
        if (keep)
            expected_chunk_bytes.push_back(r);
        mark_first = cut;
        shift_out_oldest();
    endfunction

    // Payload-like byte, heavy on zeros so that start codes turn up inside payloads.
    function automatic logic [7:0] filler_byte();
        int c;
        c = $urandom_range(9);
        if (c < 3)
            return 8'h00;
        if (c == 3)
            return 8'h01;
        if (c == 4)
            return 8'h03;
        return 8'($urandom_range(255));
    endfunction

    // Offer one byte, wait for its transfer, then update the predictor.
    task automatic send_byte(input logic [7:0] b, input logic eos, input row_kind_t kind,
                             input ncs_res_t typed);
        while ($urandom_range(99) < src_idle_pct)
        begin
            byte_bus.valid <= 1'b0;
            @(posedge clk);
        end
        byte_bus.valid         <= 1'b1;
        byte_bus.data_byte     <= b;
        byte_bus.end_of_stream <= eos;
        @(posedge clk);
        while (!byte_bus.ready)
            @(posedge clk);
        predict_chunk_bytes(b, eos, kind == ROW_PREDICT);
        if (kind == ROW_ONE_RESULT)
            expected_chunk_bytes.push_back(typed);
    endtask

    // Drop valid, let every expected transfer drain, then allow the quiet tail.
    task automatic settle();
        byte_bus.valid <= 1'b0;
        while (expected_chunk_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB read of the codec register, compared with our copy.
    task automatic check_codec();
        logic [31:0] v;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= CODEC_ADDR;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        v = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if (v !== {31'b0, codec_hevc})
            flag_mismatch($sformatf("codec register read %h, expected %h",
                                    v, {31'b0, codec_hevc}));
    endtask

    task automatic set_codec(input logic hevc);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CODEC_ADDR;
        pwdata  <= {31'b0, hevc};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        codec_hevc = hevc;
        check_codec();
    endtask

    // Random Annex B streams, each closed by an end-of-stream byte.
    // Mostly well-formed units with random headers and payloads; some noise,
    // broken start codes and streams cut short (header possibly missing).
    task automatic run_random_streams(input int items, input bit squeeze);
        int         sent;
        int         shape;
        int         keep_n;
        int         sel;
        bit         held;
        logic [7:0] hdr;
        logic [5:0] t;

        sent = 0;
        held = 1'b0;
        while (sent < items)
        begin
            stream_q.delete();
            shape = $urandom_range(99);
            if (shape < 8)
            begin
                repeat ($urandom_range(12, 1)) stream_q.push_back({1'b0, filler_byte()});
            end
            else
            begin
                if ($urandom_range(3) == 0)
                    repeat ($urandom_range(4, 1)) stream_q.push_back({1'b0, filler_byte()});
                repeat ($urandom_range(6, 1))
                begin
                    if ($urandom_range(19) == 0)
                    begin
                        // looks like a start code but is not
                        stream_q.push_back(9'h000);
                        stream_q.push_back(9'h000);
                        stream_q.push_back(9'h002);
                    end
                    else
                    begin
                        if ($urandom_range(1) == 1)
                            stream_q.push_back(9'h000);
                        stream_q.push_back(9'h000);
                        stream_q.push_back(9'h000);
                        stream_q.push_back(9'h001);
                    end
                    hdr = 8'($urandom_range(255));
                    sel = $urandom_range(9);
                    if (sel < 4)
                    begin
                        // auxiliary type under the current codec
                        if (codec_hevc)
                            hdr[6:1] = 6'($urandom_range(HEVC_AUX_HI, HEVC_AUX_LO));
                        else
                            hdr[4:0] = 5'($urandom_range(AVC_AUX_HI, AVC_AUX_LO));
                    end
                    else if (sel < 9)
                    begin
                        // VCL: any type outside the auxiliary range
                        if (codec_hevc)
                        begin
                            t = 6'($urandom_range(59));
                            if (t >= HEVC_AUX_LO)
                                t = t + 6'(HEVC_AUX_HI - HEVC_AUX_LO + 1);
                            hdr[6:1] = t;
                        end
                        else
                        begin
                            t = 6'($urandom_range(27));
                            if (t >= AVC_AUX_LO)
                                t = t + 6'(AVC_AUX_HI - AVC_AUX_LO + 1);
                            hdr[4:0] = t[4:0];
                        end
                    end
                    stream_q.push_back({1'b0, hdr});
                    repeat ($urandom_range(7)) stream_q.push_back({1'b0, filler_byte()});
                end
                if (shape < 20)
                begin
                    keep_n = $urandom_range(stream_q.size(), 1);
                    while (stream_q.size() > keep_n)
                        void'(stream_q.pop_back());
                end
            end
            stream_q[stream_q.size() - 1][8] = 1'b1;

            foreach (stream_q[i])
            begin
                send_byte(stream_q[i][7:0], stream_q[i][8], ROW_PREDICT, NONE_RES);
                sent++;
                // once per squeezed phase: receiver holds off, sender keeps offering
                if (squeeze && !held && sent >= 40)
                begin
                    hold_left = HOLD_CYCLES;
                    held      = 1'b1;
                end
            end
        end
    endtask

    // Receiver: random stalls, plus the long hold-off counted down here.
    initial
    begin
        chunk_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                chunk_bus.ready <= 1'b0;
                hold_left--;
            end
            else
                chunk_bus.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // Every result transfer is matched against the oldest expectation.
    always @(posedge clk)
    begin : chunk_check
        ncs_res_t got;
        ncs_res_t want;
        if (rst_n && chunk_bus.valid && chunk_bus.ready)
        begin
            got = {chunk_bus.out_byte, chunk_bus.first_of_chunk, chunk_bus.last_of_chunk,
                   chunk_bus.stream_end, chunk_bus.last_result};
            if (expected_chunk_bytes.size() == 0)
                flag_mismatch($sformatf("unexpected transfer: byte %02h first %b last %b end %b lr %b",
                                        got.out_byte, got.first_of_chunk, got.last_of_chunk,
                                        got.stream_end, got.last_result));
            else
            begin
                want = expected_chunk_bytes.pop_front();
                if (got !== want)
                    flag_mismatch($sformatf({"transfer mismatch: expected byte %02h first %b",
                                             " last %b end %b lr %b, got byte %02h first %b",
                                             " last %b end %b lr %b"},
                                            want.out_byte, want.first_of_chunk,
                                            want.last_of_chunk, want.stream_end,
                                            want.last_result, got.out_byte,
                                            got.first_of_chunk, got.last_of_chunk,
                                            got.stream_end, got.last_result));
            end
        end
    end

    // Watchdog: too long with no transfer on either stream means a hang.
    always @(posedge clk)
    begin
        if ((byte_bus.valid && byte_bus.ready) || (chunk_bus.valid && chunk_bus.ready))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("tb_nal_unit_chunk_splitter failed");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n                  <= 1'b0;
        psel                   <= 1'b0;
        penable                <= 1'b0;
        pwrite                 <= 1'b0;
        paddr                  <= '0;
        pwdata                 <= '0;
        byte_bus.valid         <= 1'b0;
        byte_bus.data_byte     <= 8'h00;
        byte_bus.end_of_stream <= 1'b0;
        clear_chunk_state();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // register comes out of reset as H.264
        check_codec();

        // directed table, then H.265 streams; sender idles 33 %, receiver 45 %
        foreach (DIR_ROWS[i])
            send_byte(DIR_ROWS[i].data_byte, DIR_ROWS[i].eos, DIR_ROWS[i].kind,
                      DIR_ROWS[i].res);
        settle();
        set_codec(1'b1);
        run_random_streams(PHASE_ITEMS, 1'b0);

        // back to H.264, idling the other way round
        settle();
        set_codec(1'b0);
        src_idle_pct = 45;
        snk_idle_pct = 33;
        run_random_streams(PHASE_ITEMS, 1'b0);

        // H.265 at full rate, with one long receiver hold-off
        settle();
        set_codec(1'b1);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        run_random_streams(PHASE_ITEMS, 1'b1);
        settle();

        if (mismatches == 0)
            $display("tb_nal_unit_chunk_splitter passed");
        else
            $display("tb_nal_unit_chunk_splitter failed");
        $finish;
    end

endmodule

>>> sim.f
+incdir+src
src/ncs_pkg.sv
src/ncs_if.sv
src/ncs_cfg.sv
src/ncs_scan.sv
src/ncs_obuf.sv
src/nal_unit_chunk_splitter.sv
test/tb_nal_unit_chunk_splitter.sv
